// ----- hdl/ogs_pkg.sv -----
// types, codes and the fixed level table of the off-time mode group selector
package ogs_pkg;

  localparam logic REQ_POWER_ON = 1'b0;
  localparam logic REQ_TICK     = 1'b1;

  localparam logic [2:0] CFG_LOW_BATT_THRESHOLD   = 3'd0;
  localparam logic [2:0] CFG_STEP_DOWN_TICKS      = 3'd1;
  localparam logic [2:0] CFG_PRESS_CLEAR_TICKS    = 3'd2;
  localparam logic [2:0] CFG_PROGRAM_PRESSES      = 3'd3;
  localparam logic [2:0] CFG_PROGRAM_WINDOW_TICKS = 3'd4;

  localparam logic [1:0] PAT_STEADY = 2'd0;
  localparam logic [1:0] PAT_STROBE = 2'd1;
  localparam logic [1:0] PAT_BEACON = 2'd2;

  localparam logic [7:0] LVL_STROBE = 8'd253;
  localparam logic [7:0] LVL_BEACON = 8'd252;
  localparam logic [7:0] LVL_FULL   = 8'd255;
  localparam logic [7:0] PROG_LEVEL = 8'd25;

  localparam int INIT_GROUPS = 12;
  localparam int INIT_WORDS  = 6;

  typedef enum logic [1:0] {
    PH_NORMAL = 2'd0,
    PH_FIRST  = 2'd1,
    PH_COMMIT = 2'd2,
    PH_CANCEL = 2'd3
  } phase_e;

  typedef struct packed {
    logic       req_type;
    logic       fast_press;
    logic [7:0] battery_sample;
  } req_t;

  typedef struct packed {
    logic [7:0] drive_level;
    logic [1:0] pattern;
    logic [2:0] active_mode;
    logic [3:0] active_group;
    logic [1:0] program_phase;
  } rsp_t;

  typedef struct packed {
    logic [7:0] low_batt_threshold;
    logic [7:0] step_down_ticks;
    logic [7:0] press_clear_ticks;
    logic [7:0] program_presses;
    logic [6:0] program_window_ticks;
  } cfg_t;

  typedef struct packed {
    logic [2:0] saved_mode;
    logic [3:0] saved_group;
    logic [7:0] press_count;
    logic [7:0] tick_count;
    logic [7:0] low_batt_count;
    logic [7:0] level_reg;
    phase_e     phase;
  } state_t;

  localparam cfg_t CFG_RESET = '{
    low_batt_threshold:   8'd129,
    step_down_ticks:      8'd40,
    press_clear_ticks:    8'd12,
    program_presses:      8'd15,
    program_window_ticks: 7'd16
  };

  localparam state_t STATE_RESET = '{
    saved_mode:     3'd1,
    saved_group:    4'd1,
    press_count:    8'd0,
    tick_count:     8'd0,
    low_batt_count: 8'd0,
    level_reg:      8'd0,
    phase:          PH_NORMAL
  };

  // row: memory flag, then the levels of modes 1 and up
  localparam logic [7:0] INIT_TABLE [INIT_GROUPS][INIT_WORDS] = '{
    '{8'd0, 8'd255, 8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd1, 8'd25,  8'd255, 8'd0,   8'd0,   8'd0},
    '{8'd0, 8'd25,  8'd255, 8'd0,   8'd0,   8'd0},
    '{8'd1, 8'd255, 8'd25,  8'd0,   8'd0,   8'd0},
    '{8'd0, 8'd255, 8'd25,  8'd0,   8'd0,   8'd0},
    '{8'd1, 8'd25,  8'd64,  8'd255, 8'd0,   8'd0},
    '{8'd0, 8'd25,  8'd64,  8'd255, 8'd0,   8'd0},
    '{8'd1, 8'd255, 8'd64,  8'd25,  8'd0,   8'd0},
    '{8'd0, 8'd255, 8'd64,  8'd25,  8'd0,   8'd0},
    '{8'd0, 8'd6,   8'd25,  8'd64,  8'd255, 8'd0},
    '{8'd0, 8'd25,  8'd64,  8'd255, 8'd253, 8'd0},
    '{8'd0, 8'd6,   8'd25,  8'd64,  8'd252, 8'd253}
  };

  function automatic logic [7:0] init_word(input logic [3:0] g, input logic [3:0] w);
    if (32'(g) >= INIT_GROUPS || 32'(w) >= INIT_WORDS) begin
      return 8'd0;
    end
    return INIT_TABLE[g][w[2:0]];
  endfunction

endpackage

// ----- hdl/offtime_mode_group_selector.sv -----
// top level of the off-time mode group selector
// Usage:
//   requests enter on in_valid_i / in_req_i and are taken at an edge where
//   in_valid_i is high and in_stall_o is low. a request is a power-on event
//   (with the short off-time flag) or a watchdog tick (with a battery sample).
//   every request yields exactly one result on out_valid_o / out_rsp_o, taken
//   at an edge where out_valid_o is high and out_stall_i is low.
//   a taken request waits in the input register; the state update then writes
//   its result into the result register, from which out_rsp_o is driven.
//   throughput: one request per cycle when out_stall_i is low; the mode state
//   is read and written in the same cycle, so requests chain without bubbles.
//   settings are written through cfg_we_i / cfg_idx_i / cfg_wdata_i while idle.
//   reset restores the saved mode and group to 1, clears counters and phase,
//   loads the default settings and empties both registers.
//   when the receiver stalls, the result register holds; one more request is
//   held in the input register, then in_stall_o rises until the result moves.
module offtime_mode_group_selector #(
  parameter int GROUP_COUNT = 12,
  parameter int ROW_WORDS   = 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  ogs_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output ogs_pkg::rsp_t out_rsp_o,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [7:0]    cfg_wdata_i
);
  import ogs_pkg::*;

  logic   in_valid_q, in_valid_d;
  req_t   in_req_q;
  logic   out_valid_q, out_valid_d;
  rsp_t   out_rsp_q;
  rsp_t   rsp_d;
  state_t state_q, state_d;
  cfg_t   cfg_q;
  logic   advance;
  logic   accept;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  ogs_step #(
    .GROUP_COUNT(GROUP_COUNT),
    .ROW_WORDS  (ROW_WORDS)
  ) u_step (
    .state_i(state_q),
    .cfg_i  (cfg_q),
    .req_i  (in_req_q),
    .state_o(state_d),
    .rsp_o  (rsp_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= STATE_RESET;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LOW_BATT_THRESHOLD:   cfg_q.low_batt_threshold   <= cfg_wdata_i;
        CFG_STEP_DOWN_TICKS:      cfg_q.step_down_ticks      <= cfg_wdata_i;
        CFG_PRESS_CLEAR_TICKS:    cfg_q.press_clear_ticks    <= cfg_wdata_i;
        CFG_PROGRAM_PRESSES:      cfg_q.program_presses      <= cfg_wdata_i;
        CFG_PROGRAM_WINDOW_TICKS: cfg_q.program_window_ticks <= cfg_wdata_i[6:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_req_q <= in_req_i;
    end
    if (advance) begin
      out_rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

`ifndef NO_ASSERTIONS
  // the saved mode never reaches zero
  assert property (@(posedge clk_i) disable iff (!rst_ni) state_q.saved_mode != 3'd0)
    else $error("saved mode is zero");

  // the commit window is only entered from the first window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == PH_COMMIT && $past(state_q.phase) != PH_COMMIT)
      |-> $past(state_q.phase) == PH_FIRST)
    else $error("commit window entered without first window");

  // a new result only follows a request held in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_valid_q))
    else $error("result without request");
`endif

endmodule

// ----- hdl/ogs_step.sv -----
// next state and result for one request, from the current state and settings
module ogs_step #(
  parameter int GROUP_COUNT = 12,
  parameter int ROW_WORDS   = 6
) (
  input  ogs_pkg::state_t state_i,
  input  ogs_pkg::cfg_t   cfg_i,
  input  ogs_pkg::req_t   req_i,
  output ogs_pkg::state_t state_o,
  output ogs_pkg::rsp_t   rsp_o
);
  import ogs_pkg::*;

  localparam logic [4:0] GROUPS = 5'(GROUP_COUNT);
  localparam logic [3:0] WORDS  = 4'(ROW_WORDS);
  localparam logic [3:0] LAST_GROUP = 4'(GROUP_COUNT - 1);

  function automatic logic [7:0] word_at(input logic [3:0] g, input logic [3:0] w);
    if ({1'b0, g} >= GROUPS || w >= WORDS) begin
      return 8'd0;
    end
    return init_word(g, w);
  endfunction

  // a group beyond the table reads as group 0
  function automatic logic [3:0] sel_group(input logic [3:0] grp);
    return ({1'b0, grp} < GROUPS) ? grp : 4'd0;
  endfunction

  function automatic logic [7:0] mode_level(input logic [2:0] mode, input logic [3:0] grp);
    if (mode == 3'd0) begin
      return 8'd0;
    end
    return word_at(sel_group(grp), {1'b0, mode});
  endfunction

  state_t     ns;
  logic [3:0] grp;
  logic [3:0] mode;
  logic [7:0] lvl;
  logic [7:0] low_inc;
  logic [4:0] grp_inc;
  logic [7:0] out_lvl;

  always_comb begin
    ns      = state_i;
    grp     = sel_group(state_i.saved_group);
    mode    = {1'b0, state_i.saved_mode};
    lvl     = 8'd0;
    low_inc = state_i.low_batt_count + 8'd1;
    grp_inc = {1'b0, state_i.saved_group} + 5'd1;

    if (req_i.req_type == REQ_POWER_ON) begin
      ns.tick_count     = 8'd0;
      ns.low_batt_count = 8'd0;
      ns.level_reg      = 8'd0;
      ns.phase          = PH_NORMAL;
      if (req_i.fast_press) begin
        mode = mode + 4'd1;
        if (mode > WORDS - 4'd1 || word_at(grp, mode) == 8'd0) begin
          mode = 4'd1;
        end
        if (state_i.press_count != 8'hff) begin
          ns.press_count = state_i.press_count + 8'd1;
        end
      end else begin
        // no memory flag: back to the first mode
        if (word_at(grp, 4'd0) == 8'd0) begin
          mode = 4'd1;
        end
        ns.press_count = 8'd0;
      end
      ns.saved_mode = mode[2:0];
      if (ns.press_count > cfg_i.program_presses) begin
        ns.phase = PH_FIRST;
      end else begin
        lvl = mode_level(ns.saved_mode, ns.saved_group);
        ns.level_reg = (lvl == LVL_STROBE || lvl == LVL_BEACON) ? LVL_FULL : lvl;
      end
    end else begin
      if (state_i.tick_count != 8'hff) begin
        ns.tick_count = state_i.tick_count + 8'd1;
      end
      if (ns.tick_count == cfg_i.press_clear_ticks) begin
        ns.press_count = 8'd0;
      end
      if (req_i.battery_sample < cfg_i.low_batt_threshold) begin
        ns.low_batt_count = low_inc;
        if (low_inc > cfg_i.step_down_ticks) begin
          ns.level_reg      = {1'b0, state_i.level_reg[7:1]} + 8'd3;
          ns.low_batt_count = 8'd0;
        end
      end else begin
        ns.low_batt_count = 8'd0;
      end
      if (state_i.phase == PH_FIRST &&
          ns.tick_count >= {1'b0, cfg_i.program_window_ticks}) begin
        if (grp_inc >= GROUPS) begin
          grp_inc = 5'd0;
        end
        ns.press_count = 8'd0;
        ns.saved_group = grp_inc[3:0];
        ns.saved_mode  = 3'd1;
        ns.phase       = PH_COMMIT;
      end else if (state_i.phase == PH_COMMIT &&
                   ns.tick_count >= {cfg_i.program_window_ticks, 1'b0}) begin
        // power stayed on through the commit window: revert the group
        ns.saved_group = (grp == 4'd0) ? LAST_GROUP : grp - 4'd1;
        ns.phase       = PH_CANCEL;
      end
    end
  end

  assign out_lvl = mode_level(ns.saved_mode, ns.saved_group);

  always_comb begin
    rsp_o.active_mode   = ns.saved_mode;
    rsp_o.active_group  = ns.saved_group;
    rsp_o.program_phase = ns.phase;
    rsp_o.pattern       = PAT_STEADY;
    if (ns.phase == PH_NORMAL) begin
      rsp_o.drive_level = ns.level_reg;
      if (out_lvl == LVL_STROBE) begin
        rsp_o.pattern = PAT_STROBE;
      end else if (out_lvl == LVL_BEACON) begin
        rsp_o.pattern = PAT_BEACON;
      end
    end else begin
      rsp_o.drive_level = (ns.phase == PH_COMMIT) ? 8'd0 : PROG_LEVEL;
    end
  end

  assign state_o = ns;

endmodule

// ----- tb/offtime_mode_group_selector_tb.sv -----
// testbench for the off-time mode group selector: directed and random requests, scoreboard check
`timescale 1ns / 1ps

module offtime_mode_group_selector_tb;
  import ogs_pkg::*;

  localparam int GROUP_COUNT = 12;
  localparam int ROW_WORDS   = 6;

  // mirrors the mode, group, counter and phase state and queues the expected results
  class selector_scoreboard;
    cfg_t   cfg;
    logic [2:0] mode;
    logic [3:0] grp;
    logic [7:0] presses;
    logic [7:0] ticks;
    logic [7:0] low_cnt;
    logic [7:0] level;
    phase_e     phase;
    rsp_t   expected_q[$];
    int     errors;
    int     results;
    int     power_ons;
    int     tick_reqs;
    int     commits;
    int     cancels;
    int     step_downs;
    int     flash_modes;

    function new();
      cfg     = CFG_RESET;
      mode    = STATE_RESET.saved_mode;
      grp     = STATE_RESET.saved_group;
      presses = STATE_RESET.press_count;
      ticks   = STATE_RESET.tick_count;
      low_cnt = STATE_RESET.low_batt_count;
      level   = STATE_RESET.level_reg;
      phase   = STATE_RESET.phase;
    endfunction

    function logic [7:0] level_at(int g, int w);
      if (g >= GROUP_COUNT || g >= INIT_GROUPS || w >= ROW_WORDS || w >= INIT_WORDS) begin
        return 8'd0;
      end
      return INIT_TABLE[g][w];
    endfunction

    // out-of-range groups read as group 0
    function int group_row();
      return (int'(grp) < GROUP_COUNT) ? int'(grp) : 0;
    endfunction

    function logic [7:0] mode_level();
      if (mode == 3'd0) begin
        return 8'd0;
      end
      return level_at(group_row(), int'(mode));
    endfunction

    function void set_config(logic [2:0] idx, logic [7:0] data);
      case (idx)
        CFG_LOW_BATT_THRESHOLD:   cfg.low_batt_threshold = data;
        CFG_STEP_DOWN_TICKS:      cfg.step_down_ticks = data;
        CFG_PRESS_CLEAR_TICKS:    cfg.press_clear_ticks = data;
        CFG_PROGRAM_PRESSES:      cfg.program_presses = data;
        CFG_PROGRAM_WINDOW_TICKS: cfg.program_window_ticks = data[6:0];
        default: ;
      endcase
    endfunction

    function void note_request(req_t r);
      int g;
      int m;
      logic [7:0] lvl;
      rsp_t exp_rsp;
      if (r.req_type == REQ_POWER_ON) begin
        power_ons++;
        g = group_row();
        m = int'(mode);
        ticks = 8'd0;
        low_cnt = 8'd0;
        level = 8'd0;
        phase = PH_NORMAL;
        if (r.fast_press) begin
          m++;
          if (m > ROW_WORDS - 1 || level_at(g, m) == 8'd0) begin
            m = 1;
          end
          if (presses != 8'd255) begin
            presses++;
          end
        end else begin
          // no memory flag in this group: back to the first mode
          if (level_at(g, 0) == 8'd0) begin
            m = 1;
          end
          presses = 8'd0;
        end
        mode = 3'(m);
        if (presses > cfg.program_presses) begin
          phase = PH_FIRST;
        end else begin
          lvl = mode_level();
          level = (lvl == LVL_STROBE || lvl == LVL_BEACON) ? LVL_FULL : lvl;
        end
      end else begin
        tick_reqs++;
        if (ticks != 8'd255) begin
          ticks++;
        end
        if (ticks == cfg.press_clear_ticks) begin
          presses = 8'd0;
        end
        if (r.battery_sample < cfg.low_batt_threshold) begin
          low_cnt++;
          if (low_cnt > cfg.step_down_ticks) begin
            level = (level >> 1) + 8'd3;
            low_cnt = 8'd0;
            step_downs++;
          end
        end else begin
          low_cnt = 8'd0;
        end
        if (phase == PH_FIRST && int'(ticks) >= int'(cfg.program_window_ticks)) begin
          g = int'(grp) + 1;
          if (g >= GROUP_COUNT) begin
            g = 0;
          end
          presses = 8'd0;
          grp = 4'(g);
          mode = 3'd1;
          phase = PH_COMMIT;
          commits++;
        end else if (phase == PH_COMMIT &&
                     int'(ticks) >= 2 * int'(cfg.program_window_ticks)) begin
          g = group_row();
          g = (g == 0) ? GROUP_COUNT - 1 : g - 1;
          grp = 4'(g);
          phase = PH_CANCEL;
          cancels++;
        end
      end

      exp_rsp.active_mode   = mode;
      exp_rsp.active_group  = grp;
      exp_rsp.program_phase = phase;
      if (phase == PH_NORMAL) begin
        lvl = mode_level();
        exp_rsp.drive_level = level;
        if (lvl == LVL_STROBE) begin
          exp_rsp.pattern = PAT_STROBE;
        end else if (lvl == LVL_BEACON) begin
          exp_rsp.pattern = PAT_BEACON;
        end else begin
          exp_rsp.pattern = PAT_STEADY;
        end
        if (exp_rsp.pattern != PAT_STEADY) begin
          flash_modes++;
        end
      end else begin
        exp_rsp.drive_level = (phase == PH_COMMIT) ? 8'd0 : PROG_LEVEL;
        exp_rsp.pattern = PAT_STEADY;
      end
      expected_q.push_back(exp_rsp);
    endfunction

    function void compare_field(string name, int exp_val, int got_val);
      if (exp_val != got_val) begin
        $error("%s mismatch: expected %0d, got %0d", name, exp_val, got_val);
        errors++;
      end
    endfunction

    function void check_result(rsp_t got);
      rsp_t exp_rsp;
      if (expected_q.size() == 0) begin
        $error("result with no request outstanding: %p", got);
        errors++;
        return;
      end
      exp_rsp = expected_q.pop_front();
      results++;
      compare_field("drive_level", exp_rsp.drive_level, got.drive_level);
      compare_field("pattern", exp_rsp.pattern, got.pattern);
      compare_field("active_mode", exp_rsp.active_mode, got.active_mode);
      compare_field("active_group", exp_rsp.active_group, got.active_group);
      compare_field("program_phase", exp_rsp.program_phase, got.program_phase);
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  req_t       in_req = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  rsp_t       out_rsp;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_idx = CFG_LOW_BATT_THRESHOLD;
  logic [7:0] cfg_wdata = '0;

  selector_scoreboard sb = new();
  cfg_t cur_cfg = CFG_RESET;
  int   sent_items = 0;
  bit   idle_on = 1'b1;
  bit   stall_on = 1'b1;

  offtime_mode_group_selector #(
    .GROUP_COUNT(GROUP_COUNT),
    .ROW_WORDS  (ROW_WORDS)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_rsp_o  (out_rsp),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  initial begin
    forever begin
      #5 clk = ~clk;
    end
  end

  initial begin
    #5ms;
    $display("offtime_mode_group_selector test failed");
    $finish;
  end

  // receiver stalls in short random bursts
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (stall_on && $urandom_range(4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_rsp);
    end
  end

  function automatic req_t power_req(logic fast);
    req_t r;
    r.req_type = REQ_POWER_ON;
    r.fast_press = fast;
    r.battery_sample = 8'($urandom);
    return r;
  endfunction

  function automatic req_t tick_req(logic [7:0] sample);
    req_t r;
    r.req_type = REQ_TICK;
    r.fast_press = 1'($urandom);
    r.battery_sample = sample;
    return r;
  endfunction

  // samples around the low battery threshold and at the rails
  function automatic logic [7:0] pick_sample();
    logic [7:0] thr;
    thr = cur_cfg.low_batt_threshold;
    case ($urandom_range(4))
      0: return 8'd0;
      1: return 8'd255;
      2: return (thr == 8'd0) ? 8'd0 : thr - 8'd1;
      3: return thr;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_req(req_t r);
    if (idle_on && $urandom_range(4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (in_stall);
    sb.note_request(r);
    sent_items++;
  endtask

  task automatic write_settings(cfg_t c);
    logic [7:0] vals [5];
    vals[0] = c.low_batt_threshold;
    vals[1] = c.step_down_ticks;
    vals[2] = c.press_clear_ticks;
    vals[3] = c.program_presses;
    vals[4] = {1'b0, c.program_window_ticks};
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= 3'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
      sb.set_config(3'(i), vals[i]);
    end
    cfg_we <= 1'b0;
    cur_cfg = c;
  endtask

  // enough short presses to start programming, then ticks through the windows
  task automatic program_sequence();
    int w;
    int cut;
    w = int'(cur_cfg.program_window_ticks);
    if ($urandom_range(1)) begin
      send_req(power_req(1'b0));
    end
    repeat (int'(cur_cfg.program_presses) + 1) begin
      send_req(power_req(1'b1));
      if (cur_cfg.press_clear_ticks != 8'd1 && $urandom_range(3) == 0) begin
        send_req(tick_req(pick_sample()));
      end
    end
    // half the time cut power inside the commit window
    if ($urandom_range(1)) begin
      cut = (w == 0) ? 1 : $urandom_range(w, 2 * w - 1);
    end else begin
      cut = $urandom_range(0, 2 * w + 3);
    end
    repeat (cut) send_req(tick_req(pick_sample()));
    send_req(power_req(1'($urandom)));
  endtask

  task automatic mode_walk();
    repeat ($urandom_range(2, 8)) begin
      send_req(power_req($urandom_range(3) != 0));
      repeat ($urandom_range(0, 2)) send_req(tick_req(pick_sample()));
    end
  endtask

  task automatic battery_run();
    int n;
    logic [7:0] thr;
    thr = cur_cfg.low_batt_threshold;
    n = int'(cur_cfg.step_down_ticks) + 4;
    n = $urandom_range(1, (n > 60) ? 60 : n);
    repeat (n) begin
      if (thr != 8'd0 && $urandom_range(4) != 0) begin
        send_req(tick_req(8'($urandom_range(0, int'(thr) - 1))));
      end else begin
        send_req(tick_req(8'($urandom_range(int'(thr), 255))));
      end
    end
  endtask

  task automatic random_phase(cfg_t c, int budget);
    int stop_at;
    int roll;
    write_settings(c);
    stop_at = sent_items + budget;
    while (sent_items < stop_at) begin
      roll = $urandom_range(99);
      if (c.program_presses <= 8'd20 && roll < 45) begin
        program_sequence();
      end else if (roll < 75) begin
        mode_walk();
      end else begin
        battery_run();
      end
    end
  endtask

  initial begin
    cfg_t c;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: mode wrap, step-down, programming with a one-tick window
    c = '{low_batt_threshold: 8'd255, step_down_ticks: 8'd1, press_clear_ticks: 8'd255,
          program_presses: 8'd3, program_window_ticks: 7'd1};
    write_settings(c);
    send_req(power_req(1'b0));
    repeat (5) send_req(power_req(1'b1));
    repeat (3) send_req(tick_req(8'd0));
    send_req(tick_req(8'd255));
    send_req(power_req(1'b0));
    repeat (4) send_req(power_req(1'b1));
    send_req(tick_req(8'hAA));
    send_req(tick_req(8'h55));
    send_req(tick_req(8'd0));
    send_req(power_req(1'b0));
    repeat (4) send_req(power_req(1'b1));
    send_req(tick_req(8'd254));
    send_req(power_req(1'b1));

    random_phase(CFG_RESET, 150);
    random_phase('{8'd0, 8'd255, 8'd1, 8'd1, 7'd1}, 80);
    random_phase('{8'd200, 8'd2, 8'd5, 8'd2, 7'd127}, 60);
    random_phase('{8'd255, 8'd255, 8'd255, 8'd254, 7'd3}, 70);
    // zero window and a press counter that is never cleared by ticks
    random_phase('{8'd128, 8'd3, 8'd0, 8'd4, 7'd0}, 60);
    // programming can never start
    random_phase('{8'd100, 8'd4, 8'd6, 8'd255, 7'd5}, 40);
    idle_on = 1'b0;
    stall_on = 1'b0;
    random_phase('{8'd150, 8'd5, 8'd8, 8'd1, 7'd4}, 100);

    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    $display("covered %0d requests (%0d power-ons, %0d ticks), %0d results checked",
             sent_items, sb.power_ons, sb.tick_reqs, sb.results);
    $display("group commits %0d, reverts %0d, battery step-downs %0d, flash-mode results %0d",
             sb.commits, sb.cancels, sb.step_downs, sb.flash_modes);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("offtime_mode_group_selector test passed");
    end else begin
      $display("offtime_mode_group_selector test failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/ogs_pkg.sv
hdl/ogs_step.sv
hdl/offtime_mode_group_selector.sv
tb/offtime_mode_group_selector_tb.sv
